// ===== rtl/lprc_pkg.sv =====
// Shared types and constants for the linear probing record cache.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps

package lprc_pkg;

    localparam int HASH_W  = 64;
    localparam int VAL_W   = 64;
    localparam int KIND_W  = 8;
    localparam int STAT_W  = 3;
    localparam int S_DATA_W = 264;
    localparam int M_DATA_W = 16;

    localparam logic [STAT_W-1:0] ST_GET_MISS     = 3'd0;
    localparam logic [STAT_W-1:0] ST_GET_HIT      = 3'd1;
    localparam logic [STAT_W-1:0] ST_PUT_UPDATED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_PUT_INSERTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_PUT_FULL     = 3'd4;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SLOT,
        S_CHECK,
        S_REC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic mod_step;
        logic slot_rd;
        logic rec_rd;
        logic advance;
        logic mark_found;
        logic mark_empty;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic slot_empty;
        logic slot_live;
        logic rec_match;
        logic last_probe;
        logic out_busy;
    } t_ctl_sts;

endpackage

// ===== rtl/lprc_ctrl.sv =====
// Sequencer for the record cache: clear pass, hashing, probe loop, result.
// Depends on lprc_pkg.
`timescale 1ns / 1ps

module lprc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  lprc_pkg::t_ctl_sts i_sts,
    output lprc_pkg::t_ctl_cmd o_cmd
);
    import lprc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = S_SLOT;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_SLOT: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.slot_empty) begin
                    o_cmd.mark_empty = 1'b1;
                    n_state          = S_DONE;
                end else if (i_sts.slot_live) begin
                    o_cmd.rec_rd = 1'b1;
                    n_state      = S_REC;
                end else begin
                    // stale slot: skip it like a non-matching record
                    o_cmd.advance = 1'b1;
                    n_state       = i_sts.last_probe ? S_DONE : S_SLOT;
                end
            end
            S_REC: begin
                if (i_sts.rec_match) begin
                    o_cmd.mark_found = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = i_sts.last_probe ? S_DONE : S_SLOT;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/lprc_dp.sv =====
// Datapath of the record cache: slot table, record store, hash reduction,
// probe position, compare logic and result register. Depends on lprc_pkg.
`timescale 1ns / 1ps

module lprc_dp #(
    parameter int SLOTS    = 1024,
    parameter int RECS     = 512,
    parameter int KEY_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lprc_pkg::t_ctl_cmd               i_cmd,
    output lprc_pkg::t_ctl_sts               o_sts,
    input  logic                             i_op,
    input  logic [lprc_pkg::HASH_W-1:0]      i_hash,
    input  logic [lprc_pkg::VAL_W-1:0]       i_key,
    input  logic [lprc_pkg::VAL_W-1:0]       i_time,
    input  logic [lprc_pkg::VAL_W-1:0]       i_size,
    input  logic [lprc_pkg::KIND_W-1:0]      i_kind,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [lprc_pkg::STAT_W-1:0]      o_status,
    output logic [lprc_pkg::KIND_W-1:0]      o_kind
);
    import lprc_pkg::*;

    localparam int  SW       = $clog2(SLOTS);
    localparam int  RW       = $clog2(RECS);
    localparam int  CW       = $clog2(RECS + 1);
    localparam bit  IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
    localparam int  DIG_W    = 4;
    localparam int  RECW     = HASH_W + KEY_BITS + 2 * VAL_W + KIND_W;
    localparam int  O_SIZE   = KIND_W;
    localparam int  O_TIME   = O_SIZE + VAL_W;
    localparam int  O_KEY    = O_TIME + VAL_W;
    localparam int  O_HASH   = O_KEY + KEY_BITS;

    // item held for the whole probe
    logic                r_op;
    logic [HASH_W-1:0]   r_hash;
    logic [KEY_BITS-1:0] r_key;
    logic [VAL_W-1:0]    r_time;
    logic [VAL_W-1:0]    r_size;
    logic [KIND_W-1:0]   r_kind;

    logic [SW-1:0]       r_pos;
    logic [SW-1:0]       r_nprobe;
    logic [HASH_W-1:0]   r_mod_sh;
    logic [6:0]          r_mbit;
    logic                r_found;
    logic                r_eok;
    logic [RW-1:0]       r_idx;

    logic [SW-1:0]       r_clr;
    logic [CW-1:0]       r_count;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [KIND_W-1:0]   r_kind_out;

    logic [CW-1:0]       r_slot_mem [SLOTS];
    logic [RECW-1:0]     r_rec_mem  [RECS];
    logic [CW-1:0]       r_slot_q;
    logic [RECW-1:0]     r_rec_q;

    logic [CW-1:0]       slot_m1;
    logic [RW-1:0]       slot_idx;
    logic [SW+DIG_W-1:0] mod_t;
    logic [SW+DIG_W-1:0] mod_r;
    logic [SW-1:0]       pos_next;
    logic                full;
    logic                ins_ok;
    logic                rec_we;
    logic [RW-1:0]       rec_waddr;
    logic                time_eq;
    logic                size_eq;
    logic [STAT_W-1:0]   res_status;
    logic [KIND_W-1:0]   res_kind;

    assign slot_m1  = r_slot_q - 1'b1;
    assign slot_idx = slot_m1[RW-1:0];
    assign mod_t    = {r_pos, r_mod_sh[HASH_W-1 -: DIG_W]};
    assign pos_next = (r_pos == SW'(SLOTS - 1)) ? '0 : r_pos + 1'b1;
    assign full     = (r_count == CW'(RECS));
    assign ins_ok   = !r_found && r_eok && !full;
    assign rec_we   = i_cmd.finish && (r_op == OP_PUT) && (r_found || ins_ok);
    assign rec_waddr = r_found ? r_idx : r_count[RW-1:0];
    assign time_eq  = (r_rec_q[O_TIME +: VAL_W] == r_time);
    assign size_eq  = (r_rec_q[O_SIZE +: VAL_W] == r_size);

    // subtract the largest multiple of SLOTS that fits; all compares in parallel
    always_comb begin
        mod_r = mod_t;
        for (int k = 1; k < (1 << DIG_W); k++) begin
            if (mod_t >= (SW + DIG_W)'(k * SLOTS)) begin
                mod_r = mod_t - (SW + DIG_W)'(k * SLOTS);
            end
        end
    end

    always_comb begin
        res_kind = '0;
        if (r_op == OP_GET) begin
            if (r_found && time_eq && size_eq) begin
                res_status = ST_GET_HIT;
                res_kind   = r_rec_q[KIND_W-1:0];
            end else begin
                res_status = ST_GET_MISS;
            end
        end else if (r_found) begin
            res_status = ST_PUT_UPDATED;
        end else if (ins_ok) begin
            res_status = ST_PUT_INSERTED;
        end else begin
            res_status = ST_PUT_FULL;
        end
    end

    always_comb begin
        o_sts.clear_last = (r_clr == SW'(SLOTS - 1));
        o_sts.mod_done   = IS_POW2 || (r_mbit == 7'(HASH_W / DIG_W));
        o_sts.slot_empty = (r_slot_q == '0);
        o_sts.slot_live  = (r_slot_q != '0) && (slot_m1 < r_count);
        o_sts.rec_match  = (r_rec_q[O_HASH +: HASH_W] == r_hash)
                           && (r_rec_q[O_KEY +: KEY_BITS] == r_key);
        o_sts.last_probe = (r_nprobe == SW'(SLOTS - 1));
        o_sts.out_busy   = r_out_valid && !i_m_tready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.finish && (r_op == OP_PUT) && ins_ok) r_count <= r_count + 1'b1;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_hash   <= i_hash;
            r_key    <= i_key[KEY_BITS-1:0];
            r_time   <= i_time;
            r_size   <= i_size;
            r_kind   <= i_kind;
            r_mod_sh <= i_hash;
            r_mbit   <= '0;
            r_nprobe <= '0;
            r_found  <= 1'b0;
            r_eok    <= 1'b0;
            r_pos    <= IS_POW2 ? i_hash[SW-1:0] : '0;
        end
        if (i_cmd.mod_step && !IS_POW2) begin
            // remainder by compare and subtract, one hash nibble a cycle
            r_pos    <= mod_r[SW-1:0];
            r_mod_sh <= {r_mod_sh[HASH_W-DIG_W-1:0], {DIG_W{1'b0}}};
            r_mbit   <= r_mbit + 1'b1;
        end
        if (i_cmd.advance) begin
            r_pos    <= pos_next;
            r_nprobe <= r_nprobe + 1'b1;
        end
        if (i_cmd.mark_found) r_found <= 1'b1;
        if (i_cmd.mark_empty) r_eok   <= 1'b1;
        if (i_cmd.rec_rd) r_idx <= slot_idx;
        if (i_cmd.finish) begin
            r_status   <= res_status;
            r_kind_out <= res_kind;
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_slot_mem[r_clr] <= '0;
        end else if (i_cmd.finish && (r_op == OP_PUT) && ins_ok) begin
            r_slot_mem[r_pos] <= r_count + 1'b1;
        end
        if (i_cmd.slot_rd) r_slot_q <= r_slot_mem[r_pos];
    end

    // record store
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[rec_waddr] <= {r_hash, r_key, r_time, r_size, r_kind};
        end
        if (i_cmd.rec_rd) r_rec_q <= r_rec_mem[slot_idx];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_status;
    assign o_kind     = r_kind_out;

endmodule

// ===== rtl/linear_probe_record_cache.sv =====
// Top level of the linear probing record cache: controller plus datapath.
// Depends on lprc_pkg, lprc_ctrl and lprc_dp.
`timescale 1ns / 1ps

// After reset the block sweeps the slot table to empty, one slot a cycle, and
// takes no transaction until the sweep is done. It then works on one item at
// a time: it takes the item, reduces the hash to a slot (one hash nibble a
// cycle when SLOTS is not a power of two), and for a probe that reads a record
// does a registered slot table read, a registered record store read and a
// compare; a probe that meets an empty or a stale slot reads only the slot
// table. Last it writes back and loads the result. A finished result waits in
// the output register while the next item is taken; the next result then
// holds until that one is taken.
module linear_probe_record_cache #(
    parameter int SLOTS    = 1024,
    parameter int RECS     = 512,
    parameter int KEY_BITS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // key_hash, path_key, mod_time, file_size, entry_kind
    input  logic [lprc_pkg::S_DATA_W-1:0]     i_s_tdata,
    // operation
    input  logic [0:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // status, kind_found, zero pad
    output logic [lprc_pkg::M_DATA_W-1:0]     o_m_tdata
);
    import lprc_pkg::*;

    t_ctl_cmd          cmd;
    t_ctl_sts          sts;
    logic [STAT_W-1:0] status;
    logic [KIND_W-1:0] kind;

    lprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lprc_dp #(
        .SLOTS    (SLOTS),
        .RECS     (RECS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_op       (i_s_tuser[0]),
        .i_hash     (i_s_tdata[63:0]),
        .i_key      (i_s_tdata[127:64]),
        .i_time     (i_s_tdata[191:128]),
        .i_size     (i_s_tdata[255:192]),
        .i_kind     (i_s_tdata[263:256]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (status),
        .o_kind     (kind)
    );

    assign o_m_tdata = {{(M_DATA_W - STAT_W - KIND_W){1'b0}}, kind, status};

endmodule

// ===== rtl/lprc_chk.sv =====
// Port-level checker for the record cache, bound to the top level.
// Depends on lprc_pkg and linear_probe_record_cache.
`timescale 1ns / 1ps

module lprc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [lprc_pkg::M_DATA_W-1:0] o_m_tdata
);
    import lprc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] == ST_GET_MISS || o_m_tdata[2:0] == ST_GET_HIT
            || o_m_tdata[2:0] == ST_PUT_UPDATED || o_m_tdata[2:0] == ST_PUT_INSERTED
            || o_m_tdata[2:0] == ST_PUT_FULL))
        else $error("status code out of range");

    a_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != ST_GET_HIT |-> o_m_tdata[10:3] == '0)
        else $error("kind set without a get hit");

    // one item at a time: ready drops after a transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while busy");

endmodule

bind linear_probe_record_cache lprc_chk u_lprc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== sim/linear_probe_record_cache_tb.sv =====
// Testbench for the linear probing record cache: drives get and put transactions
// with random idling on both sides and checks every result against an in-bench predictor.
// Depends on lprc_pkg and linear_probe_record_cache.
`timescale 1ns / 1ps

module linear_probe_record_cache_tb;
    import lprc_pkg::*;

    localparam int SLOTS    = 1024;
    localparam int RECS     = 512;
    localparam int N_RAND   = 800;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic             op;
        logic [63:0]      hash;
        logic [63:0]      key;
        logic [63:0]      mtime;
        logic [63:0]      fsize;
        logic [7:0]       kind;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [7:0]        kind;
    } t_res;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] i_s_tdata = '0;
    logic [0:0]         i_s_tuser = '0;
    logic               i_m_tready = 1'b0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [M_DATA_W-1:0] o_m_tdata;

    linear_probe_record_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [9:0]  slot_map [SLOTS];
    logic [63:0] rec_hash [RECS];
    logic [63:0] rec_key  [RECS];
    logic [63:0] rec_time [RECS];
    logic [63:0] rec_size [RECS];
    logic [7:0]  rec_kind [RECS];
    int          rec_used;

    t_res        expected_results [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    function automatic t_res cache_lookup(input t_req r);
        t_res res;
        int   pos, n, idx, epos;
        bit   found, eok;
        res = '0;
        found = 0; eok = 0; idx = 0; epos = 0;
        pos = int'(r.hash % 64'(SLOTS));
        for (n = 0; n < SLOTS && !found && !eok; n++) begin
            if (slot_map[pos] == 0) begin
                eok = 1; epos = pos;
            end else if (int'(slot_map[pos]) - 1 < rec_used) begin
                idx = int'(slot_map[pos]) - 1;
                if (rec_hash[idx] == r.hash && rec_key[idx] == r.key)
                    found = 1;
            end
            if (!found && !eok)
                pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
        end
        if (r.op == OP_GET) begin
            if (found && rec_time[idx] == r.mtime && rec_size[idx] == r.fsize) begin
                res.status = ST_GET_HIT;
                res.kind = rec_kind[idx];
            end else begin
                res.status = ST_GET_MISS;
            end
        end else if (found) begin
            rec_time[idx] = r.mtime; rec_size[idx] = r.fsize; rec_kind[idx] = r.kind;
            res.status = ST_PUT_UPDATED;
        end else if (rec_used >= RECS || !eok) begin
            res.status = ST_PUT_FULL;
        end else begin
            rec_hash[rec_used] = r.hash; rec_key[rec_used] = r.key;
            rec_time[rec_used] = r.mtime; rec_size[rec_used] = r.fsize;
            rec_kind[rec_used] = r.kind;
            slot_map[epos] = 10'(rec_used + 1);
            rec_used++;
            res.status = ST_PUT_INSERTED;
        end
        return res;
    endfunction

    task automatic send_item(input t_req r, input bit pinned, input t_res pin_res);
        t_res pred;
        int   gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // keep valid high for back to back transactions, drop it for a gap
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.op;
        i_s_tdata  <= {r.kind, r.fsize, r.mtime, r.key, r.hash};
        do @(posedge i_clk); while (!o_s_tready);
        pred = cache_lookup(r);
        if (pinned && pred != pin_res) begin
            $error("predictor disagrees with table: status exp %0d got %0d",
                   pin_res.status, pred.status);
            errors++;
        end
        expected_results.push_back(pinned ? pin_res : pred);
    endtask

    function automatic t_req mk(input logic op, input logic [63:0] h, input logic [63:0] k,
                                input logic [63:0] t, input logic [63:0] s,
                                input logic [7:0] kd);
        return '{op, h, k, t, s, kd};
    endfunction

    function automatic t_req rand_item(input int pool);
        t_req r;
        int   sel;
        sel = $urandom_range(0, pool - 1);
        r.op    = 1'($urandom_range(0, 1));
        // pooled hashes force collisions and probe chains; some full-range noise
        r.hash  = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                              : 64'(sel % 37) * 64'(SLOTS) + 64'(sel % 5);
        r.key   = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : 64'(sel);
        r.mtime = ($urandom_range(0, 1)) ? 64'(sel & 3) : {$urandom, $urandom};
        r.fsize = ($urandom_range(0, 1)) ? 64'(sel & 1) : {$urandom, $urandom};
        r.kind  = 8'($urandom);
        return r;
    endfunction

    // result side
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status = o_m_tdata[STAT_W-1:0];
                got.kind   = o_m_tdata[STAT_W +: 8];
                if (expected_results.size() == 0) begin
                    $error("result with none expected: status %0d", got.status);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.status != exp_r.status) begin
                        $error("status: exp %0d got %0d", exp_r.status, got.status);
                        errors++;
                    end
                    if (got.kind != exp_r.kind) begin
                        $error("kind_found: exp %0h got %0h", exp_r.kind, got.kind);
                        errors++;
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (stim_done && expected_results.size() == 0)
            i_m_tready <= 1'b1;
        else if (r < 60)
            i_m_tready <= 1'b1;
        else if (r < 97)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 1) == 1);
    end

    // watchdog; the post-reset clearing sweep is covered by the limit
    always @(posedge i_clk) begin
        if (idle_cycles > WDOG_MAX + SLOTS) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_req  tbl_req [$];
        bit    tbl_pin [$];
        t_res  tbl_res [$];
        int    i;
        logic [63:0] ones;
        ones = '1;
        for (i = 0; i < SLOTS; i++) slot_map[i] = '0;
        rec_used = 0;

        // directed table: pinned rows carry an obvious result
        tbl_req.push_back(mk(OP_GET, ones, ones, ones, ones, 8'hFF));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_GET_MISS, 8'h00});
        tbl_req.push_back(mk(OP_PUT, ones, ones, ones, ones, 8'hFF));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_PUT_INSERTED, 8'h00});
        tbl_req.push_back(mk(OP_GET, ones, ones, ones, ones, 8'h00));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_GET_HIT, 8'hFF});
        tbl_req.push_back(mk(OP_GET, ones, ones, 64'd0, ones, 8'h00));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_GET_MISS, 8'h00});
        tbl_req.push_back(mk(OP_PUT, 64'd0, 64'd0, 64'd0, 64'd0, 8'h00));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_PUT_INSERTED, 8'h00});
        tbl_req.push_back(mk(OP_GET, 64'd0, 64'd0, 64'd0, 64'd0, 8'h55));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_GET_HIT, 8'h00});
        tbl_req.push_back(mk(OP_PUT, 64'd0, 64'd0, ones, 64'd7, 8'hA5));
        tbl_pin.push_back(1); tbl_res.push_back('{ST_PUT_UPDATED, 8'h00});
        // same home slot, different key: chain of probes
        tbl_req.push_back(mk(OP_PUT, 64'(SLOTS), 64'd1, 64'd1, 64'd1, 8'h01));
        tbl_pin.push_back(0); tbl_res.push_back('0);
        tbl_req.push_back(mk(OP_PUT, 64'(2 * SLOTS), 64'd2, 64'd2, 64'd2, 8'h02));
        tbl_pin.push_back(0); tbl_res.push_back('0);
        tbl_req.push_back(mk(OP_GET, 64'(2 * SLOTS), 64'd2, 64'd2, 64'd2, 8'h00));
        tbl_pin.push_back(0); tbl_res.push_back('0);
        tbl_req.push_back(mk(OP_GET, 64'd0, 64'd1, 64'd1, 64'd1, 8'h00));
        tbl_pin.push_back(0); tbl_res.push_back('0);
        // wrap at the table end
        tbl_req.push_back(mk(OP_PUT, 64'(SLOTS - 1), 64'd9, 64'd9, 64'd9, 8'h09));
        tbl_pin.push_back(0); tbl_res.push_back('0);
        tbl_req.push_back(mk(OP_GET, 64'(SLOTS - 1), 64'd9, 64'd9, 64'd9, 8'h00));
        tbl_pin.push_back(0); tbl_res.push_back('0);
        tbl_req.push_back(mk(OP_GET, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                             64'h0F0F, 64'hF0F0, 8'h3C));
        tbl_pin.push_back(0); tbl_res.push_back('0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < tbl_req.size(); i++)
            send_item(tbl_req[i], tbl_pin[i], tbl_res[i]);

        // random: mostly colliding pooled keys
        for (i = 0; i < N_RAND / 2; i++)
            send_item(rand_item(64), 0, '0);
        // fill the record store to capacity to reach the refused case
        while (rec_used < RECS) begin
            t_req r;
            r = rand_item(64);
            r.op = OP_PUT;
            r.hash = {$urandom, $urandom};
            r.key = {$urandom, $urandom};
            send_item(r, 0, '0);
        end
        for (i = 0; i < N_RAND / 2; i++)
            send_item(rand_item(64), 0, '0);
        i_s_tvalid <= 1'b0;

        stim_done = 1'b1;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/lprc_pkg.sv
rtl/lprc_ctrl.sv
rtl/lprc_dp.sv
rtl/linear_probe_record_cache.sv
rtl/lprc_chk.sv
sim/linear_probe_record_cache_tb.sv
